/* rtl/core/hsv6_pkg.sv */
// ----------------------------------------------------------------------------
// hsv6_pkg
// Shared types and constants for the six-sector HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv6_pkg;

  localparam int HueWidth  = 11;
  localparam int ChanWidth = 8;
  localparam int FracWidth = 8;
  localparam int SectWidth = HueWidth - FracWidth;

  localparam logic [ChanWidth-1:0] ChanFull = 8'd255;
  localparam logic [FracWidth:0]   FracSpan = 9'd256;

  // Hue sectors; higher codes are out of range, black unless saturation is 0.
  typedef enum logic [SectWidth-1:0] {
    SECT_RED_GRN_UP  = 3'd0,
    SECT_GRN_RED_DN  = 3'd1,
    SECT_GRN_BLU_UP  = 3'd2,
    SECT_BLU_GRN_DN  = 3'd3,
    SECT_BLU_RED_UP  = 3'd4,
    SECT_RED_BLU_DN  = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HueWidth-1:0]  hue;
    logic [ChanWidth-1:0] saturation;
    logic [ChanWidth-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [ChanWidth-1:0] red;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] blue;
  } rgb_t;

endpackage

/* rtl/core/hsv6_hsv_if.sv */
// ----------------------------------------------------------------------------
// hsv6_hsv_if
// Valid/ready stream carrying one HSV pixel per transaction.
// ----------------------------------------------------------------------------
interface hsv6_hsv_if;

  logic          valid;
  logic          ready;
  hsv6_pkg::hsv_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* rtl/core/hsv6_rgb_if.sv */
// ----------------------------------------------------------------------------
// hsv6_rgb_if
// Valid/ready stream carrying one RGB pixel per transaction.
// ----------------------------------------------------------------------------
interface hsv6_rgb_if;

  logic          valid;
  logic          ready;
  hsv6_pkg::rgb_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* rtl/core/hsv_to_rgb_six_sector_core.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_six_sector_core
// Six-sector integer HSV to RGB converter, three-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one HSV pixel per cycle, sustaining one pixel per clock while rgb
// is not stalled, and delivers each RGB pixel from the stage-three output
// register. Stage one forms the floor level with one 8x8 multiply, stage
// two scales the ramp with one 8x9 multiply, stage three adds the floor and
// routes the channels by sector into the output register. Each stage holds
// while the stage after it is full and stalled, so back-pressure on rgb
// passes back to hsv.ready without losing or repeating a pixel. Zero
// saturation gives gray; a hue above 1535 with nonzero saturation gives black.
module hsv_to_rgb_six_sector_core (
  input  logic             clk,
  input  logic             rst,
  hsv6_hsv_if.sink         hsv,
  hsv6_rgb_if.source       rgb
);

  localparam int CW = hsv6_pkg::ChanWidth;
  localparam int FW = hsv6_pkg::FracWidth;
  localparam int SW = hsv6_pkg::SectWidth;

  // stage flags and advance enables
  logic s1_valid, s2_valid, s3_valid;
  logic adv1, adv2, adv3;

  // stage one
  logic [2*CW-1:0]  base_prod;
  logic [SW-1:0]    s1_sect;
  logic [FW-1:0]    s1_frac;
  logic [CW-1:0]    s1_val;
  logic [CW-1:0]    s1_base;
  logic             s1_gray;

  // stage two
  logic [CW-1:0]    diff;
  logic [FW:0]      factor;
  logic [CW+FW:0]   ramp_prod;
  logic [SW-1:0]    s2_sect;
  logic [CW-1:0]    s2_val;
  logic [CW-1:0]    s2_base;
  logic             s2_gray;
  logic [CW+FW:0]   s2_prod;

  // stage three
  logic [CW-1:0]    ramp;
  hsv6_pkg::rgb_t   pix_next;
  hsv6_pkg::rgb_t   s3_pix;

  assign adv3      = !s3_valid || rgb.ready;
  assign adv2      = !s2_valid || adv3;
  assign adv1      = !s1_valid || adv2;
  assign hsv.ready = adv1;

  assign base_prod = (2*CW)'(hsv6_pkg::ChanFull - hsv.data.saturation)
                   * (2*CW)'(hsv.data.brightness);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= hsv.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_sect <= hsv.data.hue[FW+SW-1:FW];
      s1_frac <= hsv.data.hue[FW-1:0];
      s1_val  <= hsv.data.brightness;
      s1_base <= base_prod[2*CW-1:CW];
      s1_gray <= (hsv.data.saturation == '0);
    end
  end

  // falling sectors scale by the complement of the fraction
  assign diff   = s1_val - s1_base;
  assign factor = s1_sect[0] ? (hsv6_pkg::FracSpan - {1'b0, s1_frac}) : {1'b0, s1_frac};
  assign ramp_prod = (CW+FW+1)'(diff) * (CW+FW+1)'(factor);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_sect <= s1_sect;
      s2_val  <= s1_val;
      s2_base <= s1_base;
      s2_gray <= s1_gray;
      s2_prod <= ramp_prod;
    end
  end

  assign ramp = s2_prod[CW+FW-1:FW] + s2_base;

  always_comb begin
    pix_next = '0;
    if (s2_gray) begin
      pix_next = '{red: s2_val, green: s2_val, blue: s2_val};
    end else begin
      case (s2_sect)
        hsv6_pkg::SECT_RED_GRN_UP: pix_next = '{red: s2_val,  green: ramp,    blue: s2_base};
        hsv6_pkg::SECT_GRN_RED_DN: pix_next = '{red: ramp,    green: s2_val,  blue: s2_base};
        hsv6_pkg::SECT_GRN_BLU_UP: pix_next = '{red: s2_base, green: s2_val,  blue: ramp};
        hsv6_pkg::SECT_BLU_GRN_DN: pix_next = '{red: s2_base, green: ramp,    blue: s2_val};
        hsv6_pkg::SECT_BLU_RED_UP: pix_next = '{red: ramp,    green: s2_base, blue: s2_val};
        hsv6_pkg::SECT_RED_BLU_DN: pix_next = '{red: s2_val,  green: s2_base, blue: ramp};
        default:                   pix_next = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_pix <= pix_next;
    end
  end

  assign rgb.valid = s3_valid;
  assign rgb.data  = s3_pix;

endmodule

/* tb/tb_hsv_to_rgb_six_sector_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_six_sector_core
// Self-checking bench for the six-sector HSV to RGB converter.
// ----------------------------------------------------------------------------
// A directed set covers the field extremes, every hue sector with its edges,
// gray pixels and hues past the last sector. Random pixels follow in four
// phases of idling: none, sender gaps, receiver stalls, and both. Every
// accepted pixel is converted by a local integer model and the RGB results
// are checked in order, channel by channel.
module tb_hsv_to_rgb_six_sector_core;

  localparam int WatchdogLimit = 2000;
  localparam int FlushCycles   = 10;
  localparam int PhaseItems    = 100;

  logic clk = 1'b0;
  logic rst;

  hsv6_hsv_if hsv ();
  hsv6_rgb_if rgb ();

  hsv_to_rgb_six_sector_core i_dut (
    .clk (clk),
    .rst (rst),
    .hsv (hsv.sink),
    .rgb (rgb.source)
  );

  hsv6_pkg::hsv_t pixel_queue[$];
  hsv6_pkg::rgb_t rgb_expected[$];
  int   sender_idle_pct;
  int   sink_stall_pct;
  int   mismatches;
  int   quiet_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic hsv6_pkg::rgb_t hsv_to_rgb_predict(hsv6_pkg::hsv_t px);
    logic [2*hsv6_pkg::ChanWidth-1:0] floor_prod;
    logic [hsv6_pkg::ChanWidth-1:0]   level;
    logic [hsv6_pkg::ChanWidth-1:0]   floor_lvl;
    logic [hsv6_pkg::FracWidth:0]     frac;
    logic [2*hsv6_pkg::ChanWidth:0]   rise_prod;
    logic [2*hsv6_pkg::ChanWidth:0]   fall_prod;
    logic [hsv6_pkg::ChanWidth-1:0]   rise;
    logic [hsv6_pkg::ChanWidth-1:0]   fall;
    hsv6_pkg::rgb_t                   px_out;
    level = px.brightness;
    if (px.saturation == '0) begin
      px_out.red   = level;
      px_out.green = level;
      px_out.blue  = level;
      return px_out;
    end
    floor_prod = (2*hsv6_pkg::ChanWidth)'(hsv6_pkg::ChanFull - px.saturation)
               * (2*hsv6_pkg::ChanWidth)'(level);
    floor_lvl  = floor_prod[2*hsv6_pkg::ChanWidth-1:hsv6_pkg::ChanWidth];
    frac       = {1'b0, px.hue[hsv6_pkg::FracWidth-1:0]};
    rise_prod  = (2*hsv6_pkg::ChanWidth+1)'(level - floor_lvl)
               * (2*hsv6_pkg::ChanWidth+1)'(frac);
    fall_prod  = (2*hsv6_pkg::ChanWidth+1)'(level - floor_lvl)
               * (2*hsv6_pkg::ChanWidth+1)'(hsv6_pkg::FracSpan - frac);
    rise       = rise_prod[hsv6_pkg::FracWidth +: hsv6_pkg::ChanWidth] + floor_lvl;
    fall       = fall_prod[hsv6_pkg::FracWidth +: hsv6_pkg::ChanWidth] + floor_lvl;
    case (hsv6_pkg::sector_t'(px.hue[hsv6_pkg::HueWidth-1:hsv6_pkg::FracWidth]))
      hsv6_pkg::SECT_RED_GRN_UP: px_out = '{red: level,     green: rise,      blue: floor_lvl};
      hsv6_pkg::SECT_GRN_RED_DN: px_out = '{red: fall,      green: level,     blue: floor_lvl};
      hsv6_pkg::SECT_GRN_BLU_UP: px_out = '{red: floor_lvl, green: level,     blue: rise};
      hsv6_pkg::SECT_BLU_GRN_DN: px_out = '{red: floor_lvl, green: fall,      blue: level};
      hsv6_pkg::SECT_BLU_RED_UP: px_out = '{red: rise,      green: floor_lvl, blue: level};
      hsv6_pkg::SECT_RED_BLU_DN: px_out = '{red: level,     green: floor_lvl, blue: fall};
      default:                   px_out = '0;
    endcase
    return px_out;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic queue_pixel(input int h, input int s, input int v);
    hsv6_pkg::hsv_t px;
    px.hue        = h[hsv6_pkg::HueWidth-1:0];
    px.saturation = s[hsv6_pkg::ChanWidth-1:0];
    px.brightness = v[hsv6_pkg::ChanWidth-1:0];
    pixel_queue.push_back(px);
  endtask

  task automatic wait_idle();
    while (pixel_queue.size() != 0 || hsv.valid || rgb_expected.size() != 0)
      @(negedge clk);
  endtask

  // Driver: advance to the next pixel once the current transaction is taken.
  always @(posedge clk) begin
    if (rst) begin
      hsv.valid <= 1'b0;
    end else begin
      if (hsv.valid && hsv.ready)
        rgb_expected.push_back(hsv_to_rgb_predict(hsv.data));
      if (!hsv.valid || hsv.ready) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          hsv.valid <= 1'b1;
          hsv.data  <= pixel_queue.pop_front();
        end else begin
          hsv.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each RGB transaction against the oldest prediction.
  always @(posedge clk) begin
    hsv6_pkg::rgb_t want;
    if (rst) begin
      rgb.ready <= 1'b0;
    end else begin
      if (rgb.valid && rgb.ready) begin
        if (rgb_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel %h", rgb.data));
        end else begin
          want = rgb_expected.pop_front();
          if (rgb.data.red !== want.red)
            report_mismatch($sformatf("red got %0d want %0d", rgb.data.red, want.red));
          if (rgb.data.green !== want.green)
            report_mismatch($sformatf("green got %0d want %0d",
                                      rgb.data.green, want.green));
          if (rgb.data.blue !== want.blue)
            report_mismatch($sformatf("blue got %0d want %0d", rgb.data.blue, want.blue));
        end
      end
      rgb.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (hsv.valid && hsv.ready) || (rgb.valid && rgb.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL hsv_to_rgb_six_sector_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int h;
    int s;
    rst             = 1'b1;
    hsv.valid       = 1'b0;
    hsv.data        = '0;
    rgb.ready       = 1'b0;
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sector edges at full and partial saturation
    queue_pixel(0, 255, 255);
    queue_pixel(255, 255, 255);
    queue_pixel(256, 255, 255);
    queue_pixel(511, 200, 255);
    queue_pixel(512, 128, 200);
    queue_pixel(767, 1, 255);
    queue_pixel(768, 255, 128);
    queue_pixel(1023, 90, 77);
    queue_pixel(1024, 255, 255);
    queue_pixel(1279, 170, 1);
    queue_pixel(1280, 255, 255);
    queue_pixel(1535, 255, 255);
    queue_pixel(1152, 64, 255);
    // black and gray pixels
    queue_pixel(640, 255, 0);
    queue_pixel(0, 0, 0);
    queue_pixel(1535, 0, 255);
    queue_pixel(300, 0, 123);
    // hue past the last sector
    queue_pixel(2047, 0, 200);
    queue_pixel(1536, 255, 255);
    queue_pixel(2047, 1, 255);
    queue_pixel(1792, 128, 99);
    wait_idle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 50; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 50; end
        default: begin sender_idle_pct = 20; sink_stall_pct = 20; end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        h = ($urandom_range(19) == 0) ? $urandom_range(2047, 1536) : $urandom_range(1535);
        case ($urandom_range(9))
          0:       s = 0;
          1:       s = 255;
          default: s = $urandom_range(255);
        endcase
        queue_pixel(h, s, $urandom_range(255));
      end
      wait_idle();
    end

    repeat (FlushCycles) @(posedge clk);
    if (mismatches == 0 && rgb_expected.size() == 0)
      $display("PASS hsv_to_rgb_six_sector_core");
    else
      $display("FAIL hsv_to_rgb_six_sector_core");
    $finish;
  end

endmodule
